// ===== rtl/vrzrle_pkg.sv =====
`timescale 1ns / 1ps
package vrzrle_pkg;

  // Fixed field widths of the interface.
  localparam int LEAF_COUNT_W = 13;
  localparam int BYTE_W       = 8;
  localparam int ROW_WORD_W   = 64;

  // Leaf count after reset, and the byte that an all-visible row is made of.
  localparam logic [LEAF_COUNT_W-1:0] LEAF_COUNT_RESET = 13'd4096;
  localparam logic [BYTE_W-1:0]       FILL_BYTE        = 8'hff;
  localparam logic [BYTE_W-1:0]       ZERO_BYTE        = 8'h00;

  // Input action codes.
  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_FILL = 1'b1;

  // Control from the sequencer to the word packer.
  typedef struct packed {
    logic              push;
    logic              restart;
    logic [BYTE_W-1:0] data;
  } pack_ctl_t;

endpackage

// ===== rtl/vis_row_zero_rle_decoder.sv =====
`timescale 1ns / 1ps
// Zero-run visibility row decoder. Each input transaction carries one
// compressed byte (action 0) or asks for an all-visible row (action 1). A
// nonzero byte becomes one row byte; a zero byte followed by a count byte
// becomes that many zero row bytes, clipped at the row's end. Rows are
// ceil(leaf count/8) bytes long and leave as 64-bit words, first byte in bits
// 7 to 0, with the final word zero-padded and flagged by last_word. Row bytes
// are built one per cycle, except while the output register holds them off,
// in a word-wide shift register that takes one byte at a time. A literal,
// marker or count byte is first accepted, after which a zero run or an
// all-visible row produces its row bytes in turn, and a row that ends part
// way through a word is then padded with zero bytes to fill that word. The
// input is held off during a run, a fill or padding, and while a finished
// word waits in the output register and the next byte would complete another.
// The user must write the leaf count through the cfg port only while the block
// is idle; the block itself has no check for this and always accepts it.
module vis_row_zero_rle_decoder #(
  parameter int MAX_LEAFS  = 4096,
  parameter int WORD_BYTES = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // Configuration write channel.
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [vrzrle_pkg::LEAF_COUNT_W-1:0]    cfg_data,
  // Compressed input channel.
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   action,
  input  logic [vrzrle_pkg::BYTE_W-1:0]          data_byte,
  // Row word output channel.
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [vrzrle_pkg::ROW_WORD_W-1:0]      row_word,
  output logic                                   last_word
);

  localparam int WORD_W = WORD_BYTES * vrzrle_pkg::BYTE_W;
  localparam int LANE_W = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;
  localparam int ROW_W  = $clog2(MAX_LEAFS / 8 + 1);
  localparam int NL_W   = vrzrle_pkg::LEAF_COUNT_W + 1;
  localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(WORD_BYTES - 1);

  typedef enum logic [1:0] {
    ST_TAKE,
    ST_RUN,
    ST_FILL,
    ST_PAD
  } state_t;

  // Row length in bytes, with the leaf count clamped to 1..MAX_LEAFS.
  function automatic logic [ROW_W-1:0] row_len_of(
    input logic [vrzrle_pkg::LEAF_COUNT_W-1:0] leafs
  );
    logic [NL_W-1:0] n;
    logic [NL_W-1:0] sum;
    n = {1'b0, leafs};
    if (n == '0) begin
      n = NL_W'(1);
    end else if (n > NL_W'(MAX_LEAFS)) begin
      n = NL_W'(MAX_LEAFS);
    end
    sum = n + NL_W'(7);
    return sum[ROW_W+2:3];
  endfunction

  state_t                        state;
  logic                          count_pending;
  logic [vrzrle_pkg::BYTE_W-1:0] run_left;
  logic [ROW_W-1:0]              bytes_done;
  logic [ROW_W-1:0]              row_len;

  vrzrle_pkg::pack_ctl_t         ctl;
  logic [WORD_W-1:0]             shifted;
  logic [LANE_W-1:0]             lane;

  logic [ROW_W:0]                done_inc;
  logic                          ends_row;
  logic                          word_full;
  logic                          completes;
  logic                          out_free;
  logic                          can_push;
  logic                          take;
  logic                          literal;

  assign cfg_ready = 1'b1;

  // Row length register, updated on each configuration transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_len <= row_len_of(vrzrle_pkg::LEAF_COUNT_RESET);
    end else if (cfg_valid && cfg_ready) begin
      row_len <= row_len_of(cfg_data);
    end
  end

  // What the next pushed byte would do to the row and to the word.
  assign done_inc  = {1'b0, bytes_done} + 1'b1;
  assign ends_row  = (state != ST_PAD) && (done_inc >= {1'b0, row_len});
  assign word_full = (lane == LAST_LANE);
  assign completes = word_full || ends_row;
  assign out_free  = !out_valid || out_ready;
  assign can_push  = out_free || !completes;

  assign in_ready = (state == ST_TAKE) && can_push;
  assign take     = in_valid && in_ready;
  assign literal  = take && (action == vrzrle_pkg::ACT_DATA) && !count_pending
                    && (data_byte != vrzrle_pkg::ZERO_BYTE);

  // Byte fed into the packer this cycle.
  always_comb begin
    ctl.push    = 1'b0;
    ctl.restart = 1'b0;
    ctl.data    = vrzrle_pkg::ZERO_BYTE;
    case (state)
      ST_TAKE: begin
        ctl.push    = literal;
        ctl.restart = take && (action == vrzrle_pkg::ACT_FILL);
        ctl.data    = data_byte;
      end
      ST_RUN: begin
        ctl.push = can_push;
      end
      ST_FILL: begin
        ctl.push = can_push;
        ctl.data = vrzrle_pkg::FILL_BYTE;
      end
      ST_PAD: begin
        ctl.push = can_push;
      end
      default: begin
        ctl.push = 1'b0;
      end
    endcase
  end

  vrzrle_packer #(
    .WORD_BYTES(WORD_BYTES)
  ) u_packer (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .shifted(shifted),
    .lane   (lane)
  );

  // Sequencer state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_TAKE;
      count_pending <= 1'b0;
      run_left      <= '0;
      bytes_done    <= '0;
      out_valid     <= 1'b0;
    end else begin
      // A word leaves when it fills; the word that closes a row is flagged.
      if (ctl.push && word_full) begin
        out_valid <= 1'b1;
        row_word  <= vrzrle_pkg::ROW_WORD_W'(shifted);
        last_word <= (state == ST_PAD) || ends_row;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // Row byte count; a row that ends mid-word goes on to padding.
      if (ctl.push && (state != ST_PAD)) begin
        if (ends_row) begin
          bytes_done <= '0;
        end else begin
          bytes_done <= done_inc[ROW_W-1:0];
        end
      end

      case (state)
        ST_TAKE: begin
          if (take) begin
            if (action == vrzrle_pkg::ACT_FILL) begin
              count_pending <= 1'b0;
              bytes_done    <= '0;
              state         <= ST_FILL;
            end else if (count_pending) begin
              count_pending <= 1'b0;
              run_left      <= data_byte;
              if (data_byte != vrzrle_pkg::ZERO_BYTE) begin
                state <= ST_RUN;
              end
            end else if (data_byte == vrzrle_pkg::ZERO_BYTE) begin
              count_pending <= 1'b1;
            end else if (ends_row && !word_full) begin
              state <= ST_PAD;
            end
          end
        end
        ST_RUN: begin
          if (ctl.push) begin
            run_left <= run_left - 1'b1;
            if (ends_row) begin
              state <= word_full ? ST_TAKE : ST_PAD;
            end else if (run_left == vrzrle_pkg::BYTE_W'(1)) begin
              state <= ST_TAKE;
            end
          end
        end
        ST_FILL: begin
          if (ctl.push && ends_row) begin
            state <= word_full ? ST_TAKE : ST_PAD;
          end
        end
        ST_PAD: begin
          if (ctl.push && word_full) begin
            state <= ST_TAKE;
          end
        end
        default: begin
          state <= ST_TAKE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/vrzrle_packer.sv =====
`timescale 1ns / 1ps
module vrzrle_packer #(
  parameter int WORD_BYTES = 8,
  localparam int WORD_W = WORD_BYTES * vrzrle_pkg::BYTE_W,
  localparam int LANE_W = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  vrzrle_pkg::pack_ctl_t ctl,
  output logic [WORD_W-1:0]     shifted,
  output logic [LANE_W-1:0]     lane
);

  localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(WORD_BYTES - 1);

  logic [WORD_W-1:0]                        word;
  logic [WORD_W+vrzrle_pkg::BYTE_W-1:0]     joined;

  // A new byte enters at the top and the oldest byte moves towards bit 0, so
  // after a full word the first byte of the word sits in bits 7 to 0.
  assign joined  = {ctl.data, word};
  assign shifted = joined[WORD_W+vrzrle_pkg::BYTE_W-1:vrzrle_pkg::BYTE_W];

  // Byte shift register.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      word <= shifted;
    end
  end

  // Byte position within the word being assembled.
  always_ff @(posedge clk) begin
    if (rst) begin
      lane <= '0;
    end else if (ctl.restart) begin
      lane <= '0;
    end else if (ctl.push) begin
      if (lane == LAST_LANE) begin
        lane <= '0;
      end else begin
        lane <= lane + 1'b1;
      end
    end
  end

endmodule
